/* design/gcem_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the grid cell averaging map.
package gcem_pkg;

   localparam logic [1:0] REQ_OBSERVE = 2'd0;
   localparam logic [1:0] REQ_WRITE   = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;
   localparam logic [1:0] REQ_CLEAR   = 2'd3;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_LIMIT_X  = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd2;
   localparam logic [2:0] CSR_LIMIT_Y  = 3'd3;
   localparam logic [2:0] CSR_PITCH    = 3'd4;
   localparam logic [2:0] CSR_WEIGHT   = 3'd5;

   localparam logic [15:0] UNITY_Q14 = 16'd16384;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [15:0] obs_rssi;
      logic signed [15:0] obs_phase_noise;
      logic [15:0]        new_attenuation;
      logic signed [15:0] new_multipath;
      logic [15:0]        new_metal_prob;
      logic signed [15:0] new_bias;
      logic [15:0]        new_reliability;
   } req_type_t_type;

   typedef struct packed {
      logic               hit;
      logic [15:0]        attenuation;
      logic signed [15:0] multipath;
      logic [15:0]        metal_prob;
      logic signed [15:0] bias;
      logic [15:0]        reliability;
   } rsp_type;

endpackage

/* design/grid_cell_ema_map_top.sv */
`timescale 1ns / 1ps
// An accepted request runs four chained divisions on the shared divider
// (cells per row, rows, column, row), then multiply, range check, cell read, blend, write-back.
// One request at a time: the next is taken only once the result has been accepted, as
// the shared divider and the single cell update are in use until then.
// A clear walks all MAX_CELLS entries, one per cycle, and then gives its result.
// After reset the same walk runs first while req_stall stays high.
module grid_cell_ema_map_top #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  gcem_pkg::req_type_t_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output gcem_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [19:0]               csr_data
);

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam logic [AW:0] LAST = (AW + 1)'(MAX_CELLS - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DCX   = 4'd2;
   localparam logic [3:0] S_DCY   = 4'd3;
   localparam logic [3:0] S_DIX   = 4'd4;
   localparam logic [3:0] S_DIY   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_IDX   = 4'd7;
   localparam logic [3:0] S_READ  = 4'd8;
   localparam logic [3:0] S_MULB  = 4'd9;
   localparam logic [3:0] S_WB    = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic signed [19:0] orgx_ff, limx_ff, orgy_ff, limy_ff;
   logic [15:0] pitch_ff, wt_ff;
   gcem_pkg::req_type_t_type req_ff;
   logic [AW:0] clr_ff, clr_in;

   logic signed [21:0] cx_ff, cy_ff, ix_ff, iy_ff;
   logic signed [44:0] prod_ff;
   logic signed [45:0] idx_ff;
   logic hit_ff;

   logic [47:0] st_mem [MAX_CELLS];
   logic [31:0] av_mem [MAX_CELLS];
   logic [47:0] st_rd_ff;
   logic [31:0] av_rd_ff;
   logic [AW-1:0] addr_ff;
   logic signed [33:0] bmp_ff, bbi_ff;

   logic rsp_valid_ff;
   gcem_pkg::rsp_type rsp_ff;

   logic div_start, div_done;
   logic signed [20:0] div_num;
   logic signed [21:0] div_q;

   gcem_div u_div (
      .clock, .reset, .start(div_start), .dividend(div_num), .divisor(pitch_ff),
      .done(div_done), .quotient(div_q)
   );

   assign csr_ready = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orgx_ff  <= '0;
         limx_ff  <= 20'sd16128;
         orgy_ff  <= '0;
         limy_ff  <= 20'sd16128;
         pitch_ff <= 16'd256;
         wt_ff    <= 16'd6554;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gcem_pkg::CSR_ORIGIN_X: orgx_ff  <= csr_data;
            gcem_pkg::CSR_LIMIT_X:  limx_ff  <= csr_data;
            gcem_pkg::CSR_ORIGIN_Y: orgy_ff  <= csr_data;
            gcem_pkg::CSR_LIMIT_Y:  limy_ff  <= csr_data;
            gcem_pkg::CSR_PITCH:    pitch_ff <= csr_data[15:0];
            gcem_pkg::CSR_WEIGHT:   wt_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // one division per step, started on entry
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      case (state_ff)
         S_IDLE: begin
            div_start = req_valid && !req_stall;
            div_num   = 21'(limx_ff) - 21'(orgx_ff);
         end
         S_DCX: begin
            div_start = div_done;
            div_num   = 21'(limy_ff) - 21'(orgy_ff);
         end
         S_DCY: begin
            div_start = div_done;
            div_num   = 21'(req_ff.pos_x) - 21'(orgx_ff);
         end
         S_DIX: begin
            div_start = div_done;
            div_num   = 21'(req_ff.pos_y) - 21'(orgy_ff);
         end
         default: ;
      endcase
   end

   logic signed [17:0] ema_w, ema_a;
   logic signed [15:0] old_mp, old_bi;
   assign ema_w  = $signed({2'b01, 16'd0}) - $signed({2'b00, wt_ff});
   assign ema_a  = $signed({2'b00, wt_ff});
   assign old_mp = av_rd_ff[31:16];
   assign old_bi = av_rd_ff[15:0];

   logic signed [45:0] total;
   always_comb begin
      total = 46'(prod_ff);
      if (cx_ff <= 22'sd0 || cy_ff <= 22'sd0) total = '0;
      else if (prod_ff > 45'(MAX_CELLS)) total = 46'(MAX_CELLS);
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + (AW + 1)'(1);
            if (clr_ff == LAST) state_in = S_OUT;
         end
         S_IDLE: if (req_valid && !req_stall) begin
            if (req_data.req_type == gcem_pkg::REQ_CLEAR) begin
               state_in = S_CLEAR;
               clr_in   = '0;
            end else begin
               state_in = S_DCX;
            end
         end
         S_DCX: if (div_done) state_in = S_DCY;
         S_DCY: if (div_done) state_in = S_DIX;
         S_DIX: if (div_done) state_in = S_DIY;
         S_DIY: if (div_done) state_in = S_MUL;
         S_MUL:  state_in = S_IDX;
         S_IDX:  state_in = S_READ;
         S_READ: state_in = S_MULB;
         S_MULB: state_in = S_WB;
         S_WB:   state_in = S_OUT;
         S_OUT:  if (!rsp_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         // the reset sweep ends in S_OUT without a pending transaction
         if (state_ff == S_WB) rsp_valid_ff <= 1'b1;
         if (state_ff == S_CLEAR && clr_ff == LAST && req_ff.req_type == gcem_pkg::REQ_CLEAR
             && hit_ff)
            rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) hit_ff <= 1'b0;          // marks that a clear came from a request
      else if (state_ff == S_IDLE && req_valid && !req_stall) hit_ff <= 1'b1;
      else if (state_ff == S_IDX) hit_ff <= (idx_ff >= 46'sd0) && (idx_ff < total);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && !req_stall) req_ff <= req_data;
      if (state_ff == S_DCX && div_done) cx_ff <= div_q + 22'sd1;
      if (state_ff == S_DCY && div_done) cy_ff <= div_q + 22'sd1;
      if (state_ff == S_DIX && div_done) ix_ff <= div_q;
      if (state_ff == S_DIY && div_done) iy_ff <= div_q;
      if (state_ff == S_MUL) begin
         prod_ff <= 45'(cx_ff * cy_ff);
         idx_ff  <= 46'(iy_ff * cx_ff) + 46'(ix_ff);
      end
      if (state_ff == S_IDX) addr_ff <= idx_ff[AW-1:0];
      if (state_ff == S_READ) begin
         st_rd_ff <= st_mem[addr_ff];
         av_rd_ff <= av_mem[addr_ff];
      end
      if (state_ff == S_MULB) begin
         bmp_ff <= 34'(ema_w * old_mp) + 34'(ema_a * req_ff.obs_phase_noise) + 34'sd32768;
         bbi_ff <= 34'(ema_w * old_bi) + 34'(ema_a * req_ff.obs_rssi) + 34'sd32768;
      end
   end

   logic [47:0] st_new;
   logic [31:0] av_new;
   always_comb begin
      st_new = st_rd_ff;
      av_new = av_rd_ff;
      case (req_ff.req_type)
         gcem_pkg::REQ_OBSERVE: av_new = {bmp_ff[31:16], bbi_ff[31:16]};
         gcem_pkg::REQ_WRITE: begin
            st_new = {req_ff.new_attenuation, req_ff.new_metal_prob, req_ff.new_reliability};
            av_new = {req_ff.new_multipath, req_ff.new_bias};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         st_mem[clr_ff[AW-1:0]] <= {gcem_pkg::UNITY_Q14, 16'd0, gcem_pkg::UNITY_Q14};
         av_mem[clr_ff[AW-1:0]] <= '0;
      end else if (state_ff == S_WB && hit_ff) begin
         st_mem[addr_ff] <= st_new;
         av_mem[addr_ff] <= av_new;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WB) begin
         if (hit_ff) begin
            rsp_ff <= {1'b1, st_new[47:32], av_new[31:16], st_new[31:16], av_new[15:0],
                       st_new[15:0]};
         end else begin
            rsp_ff <= {1'b0, gcem_pkg::UNITY_Q14, 64'd0};
         end
      end else if (state_ff == S_CLEAR) begin
         rsp_ff <= {1'b0, gcem_pkg::UNITY_Q14, 64'd0};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/gcem_div.sv */
`timescale 1ns / 1ps
// Restoring divider: signed 21-bit dividend by unsigned 16-bit divisor, truncating.
module gcem_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [20:0] dividend,
   input  logic [15:0]        divisor,
   output logic               done,
   output logic signed [21:0] quotient
);

   logic [20:0] rem_ff, rem_in;
   logic [20:0] quo_ff, quo_in;
   logic [15:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [20:0] mag;
   logic [21:0] trial;

   assign mag   = dividend[20] ? 21'(-dividend) : 21'(dividend);
   assign trial = {rem_ff, quo_ff[20]} - {6'd0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = mag;
         dsr_in  = (divisor == 16'd0) ? 16'd1 : divisor;
         neg_in  = dividend[20];
         cnt_in  = 5'd21;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[21]) begin
            rem_in = trial[20:0];
            quo_in = {quo_ff[19:0], 1'b1};
         end else begin
            rem_in = {rem_ff[19:0], quo_ff[20]};
            quo_in = {quo_ff[19:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

/* design/gcem_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the grid cell averaging map, bound to the top level.
module gcem_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input gcem_pkg::rsp_type        rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_miss_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.attenuation == gcem_pkg::UNITY_Q14
         && rsp_data.bias == 16'sd0 && rsp_data.reliability == 16'd0)
      else $error("miss result not default");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result right after acceptance");

endmodule

bind grid_cell_ema_map_top gcem_checker u_gcem_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
